FILE: rtl/b32_pkg.sv
package b32_pkg;

    localparam int GROUP_W = 40;
    localparam int RUN_MAX = 8;

    localparam logic [7:0] PAD_CHAR     = 8'h3D;
    localparam logic [7:0] UPPER_A      = 8'h41;
    localparam logic [7:0] UPPER_Z      = 8'h5A;
    localparam logic [7:0] DIGIT_2      = 8'h32;
    localparam logic [7:0] DIGIT_7      = 8'h37;

    // one burst of results caused by a single input word
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [3:0]              count;
        logic                    bad;
    } run_t;

    // 5-bit symbol to alphabet character, A..Z then 2..7
    function automatic logic [7:0] sym_char(input logic [4:0] idx);
        logic [7:0] ch;
        if (idx < 5'd26)
            ch = UPPER_A + {3'b000, idx};
        else
            ch = DIGIT_2 + {3'b000, idx - 5'd26};
        return ch;
    endfunction

    function automatic logic sym_ok(input logic [7:0] ch);
        return (ch inside {[UPPER_A:UPPER_Z]}) || (ch inside {[DIGIT_2:DIGIT_7]});
    endfunction

    function automatic logic [4:0] sym_val(input logic [7:0] ch);
        logic [7:0] v;
        if (ch inside {[UPPER_A:UPPER_Z]})
            v = ch - UPPER_A;
        else
            v = ch - DIGIT_2 + 8'd26;
        return v[4:0];
    endfunction

    // characters kept before padding for a partial group of n bytes
    function automatic logic [3:0] pad_keep(input logic [2:0] n);
        logic [3:0] k;
        case (n)
            3'd1:    k = 4'd2;
            3'd2:    k = 4'd4;
            3'd3:    k = 4'd5;
            3'd4:    k = 4'd7;
            default: k = 4'd8;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/b32_core.sv
module b32_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    input  logic          item_valid,
    input  logic [7:0]    item_byte,
    input  logic          item_eos,
    input  logic          advance,
    output logic          consume,
    output logic          run_valid,
    output b32_pkg::run_t run
);
    import b32_pkg::*;

    logic                 mode_reg;
    logic [GROUP_W-1:0]   gb_reg, gb_next;
    logic [3:0]           gc_reg, gc_next;
    logic [3:0]           dc_reg, dc_next;
    logic                 ps_reg, ps_next;
    logic                 err_reg, err_next;

    logic [2:0]           pos;
    logic [2:0]           gcn;
    logic [5:0]           enc_shamt;
    logic [GROUP_W-1:0]   gb_enc;
    logic [3:0]           keep;
    logic                 dec_bad;
    logic [GROUP_W-1:0]   gb_dec;
    logic [3:0]           dc_dec;
    logic                 ps_dec;
    logic [3:0]           gc_dec;
    logic [5:0]           dec_shamt;
    logic [5:0]           bits5;
    logic                 clr;
    run_t                 run_c;

    always_comb
    begin
        run_c     = '0;
        gb_next   = gb_reg;
        gc_next   = gc_reg;
        dc_next   = dc_reg;
        ps_next   = ps_reg;
        err_next  = err_reg;
        clr       = 1'b0;
        pos       = (gc_reg < 4'd5) ? gc_reg[2:0] : 3'd4;
        gcn       = pos + 3'd1;
        enc_shamt = 6'd32 - {pos, 3'b000};
        gb_enc    = gb_reg | (GROUP_W'(item_byte) << enc_shamt);
        keep      = (gcn == 3'd5) ? 4'd8 : pad_keep(gcn);
        dec_bad   = 1'b0;
        gb_dec    = gb_reg;
        dc_dec    = dc_reg;
        ps_dec    = ps_reg;
        dec_shamt = 6'd35 - (6'({2'b00, dc_reg}) * 6'd5);
        gc_dec    = (gc_reg < 4'd8) ? gc_reg + 4'd1 : 4'd8;
        bits5     = '0;

        if (!mode_reg)
        begin
            if (gcn == 3'd5 || item_eos)
            begin
                for (int i = 0; i < RUN_MAX; i++)
                begin
                    run_c.bytes[i] = (4'(i) < keep) ? sym_char(gb_enc[39-5*i -: 5]) : PAD_CHAR;
                end
                run_c.count = 4'd8;
                clr = 1'b1;
            end
            else
            begin
                gb_next = gb_enc;
                gc_next = {1'b0, gcn};
            end
        end
        else if (err_reg)
        begin
            clr = item_eos;
        end
        else
        begin
            if (!ps_reg)
            begin
                if (item_byte == PAD_CHAR)
                    ps_dec = 1'b1;
                else if (!sym_ok(item_byte))
                    dec_bad = 1'b1;
                else if (dc_reg < 4'd8)
                begin
                    gb_dec = gb_reg | (GROUP_W'(sym_val(item_byte)) << dec_shamt);
                    dc_dec = dc_reg + 4'd1;
                end
            end

            if (dec_bad)
            begin
                run_c.count = 4'd1;
                run_c.bad   = 1'b1;
                err_next    = 1'b1;
                clr         = 1'b1;
            end
            else if (gc_dec == 4'd8)
            begin
                // floor(5n/8) bytes from a full group
                bits5 = 6'({2'b00, dc_dec}) * 6'd5;
                for (int k = 0; k < 5; k++)
                begin
                    run_c.bytes[k] = gb_dec[39-8*k -: 8];
                end
                run_c.count = {1'b0, bits5[5:3]};
                clr = 1'b1;
            end
            else
            begin
                gb_next = gb_dec;
                gc_next = gc_dec;
                dc_next = dc_dec;
                ps_next = ps_dec;
                clr     = item_eos;
            end
        end

        if (clr)
        begin
            gb_next = '0;
            gc_next = '0;
            dc_next = '0;
            ps_next = 1'b0;
        end
    end

    // words with no results never wait on the output side
    assign consume   = item_valid && (advance || run_c.count == 4'd0);
    assign run_valid = consume && run_c.count != 4'd0;
    assign run       = run_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            gb_reg   <= '0;
            gc_reg   <= '0;
            dc_reg   <= '0;
            ps_reg   <= 1'b0;
            err_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
            gb_reg   <= '0;
            gc_reg   <= '0;
            dc_reg   <= '0;
            ps_reg   <= 1'b0;
        end
        else if (consume)
        begin
            gb_reg  <= gb_next;
            gc_reg  <= gc_next;
            dc_reg  <= dc_next;
            ps_reg  <= ps_next;
            err_reg <= err_next;
        end
    end

endmodule

FILE: rtl/b32_serializer.sv
module b32_serializer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          run_valid,
    input  b32_pkg::run_t run,
    output logic          advance,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          last_of_run,
    output logic          bad_input
);
    import b32_pkg::*;

    logic       pend_valid_reg;
    run_t       pend_reg;
    run_t       act_reg;
    logic [3:0] left_reg;
    logic [2:0] idx_reg;
    logic       act_done;
    logic       load_act;

    assign out_valid   = left_reg != 4'd0;
    assign out_byte    = act_reg.bytes[idx_reg];
    assign last_of_run = left_reg == 4'd1;
    assign bad_input   = act_reg.bad;

    assign act_done = !out_valid || (out_ready && left_reg == 4'd1);
    assign load_act = act_done && pend_valid_reg;
    assign advance  = !pend_valid_reg || act_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            left_reg       <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            if (run_valid)
                pend_valid_reg <= 1'b1;
            else if (load_act)
                pend_valid_reg <= 1'b0;

            if (load_act)
            begin
                left_reg <= pend_reg.count;
                idx_reg  <= '0;
            end
            else if (out_valid && out_ready)
            begin
                left_reg <= left_reg - 4'd1;
                idx_reg  <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_valid)
            pend_reg <= run;
        if (load_act)
            act_reg <= pend_reg;
    end

endmodule

FILE: rtl/base32_stream_codec_top.sv
// path: an accepted word passes the input register, the pending run and the active run before out_valid
// throughput: one input word per cycle while no results are pending; results leave
// one per cycle while out_ready is high
// reset: rst_n clears mode to encode, group state, sticky error and all valid flags
module base32_stream_codec_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       bad_input
);
    import b32_pkg::*;

    logic       item_valid_reg;
    logic [7:0] item_byte_reg;
    logic       item_eos_reg;
    logic       consume;
    logic       advance;
    logic       run_valid;
    run_t       run;

    assign in_ready = !item_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_byte_reg <= in_byte;
            item_eos_reg  <= end_of_stream;
        end
    end

    b32_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid_reg),
        .item_byte  (item_byte_reg),
        .item_eos   (item_eos_reg),
        .advance    (advance),
        .consume    (consume),
        .run_valid  (run_valid),
        .run        (run)
    );

    b32_serializer u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .run_valid   (run_valid),
        .run         (run),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .bad_input   (bad_input)
    );

endmodule

FILE: rtl/b32_checker.sv
module b32_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       bad_input
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(last_of_run) && $stable(bad_input))
        else $error("output word changed while stalled");

    // error result is a single zero word
    a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_input |-> last_of_run && out_byte == 8'h00)
        else $error("error word malformed");

    // words of one run come out without gaps
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid && !bad_input)
        else $error("gap inside a run");

    // checked in the cycle after rst_n is sampled low
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind base32_stream_codec_top b32_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .bad_input   (bad_input)
);

FILE: tb/tb_base32_stream_codec_top.sv
`timescale 1ns / 1ps

module tb_base32_stream_codec_top;

    import b32_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } out_word_t;

    class base32_scoreboard;
        bit        decode_mode;
        bit [39:0] group_bits;
        int        group_cnt;
        int        data_cnt;
        bit        pad_seen;
        bit        error_latched;
        string     alphabet;
        out_word_t expected_out[$];
        int        mismatches;

        function new();
            alphabet      = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
            decode_mode   = 1'b0;
            error_latched = 1'b0;
            mismatches    = 0;
            clear_group();
        endfunction

        function void clear_group();
            group_bits = '0;
            group_cnt  = 0;
            data_cnt   = 0;
            pad_seen   = 1'b0;
        endfunction

        function void set_mode(bit m);
            decode_mode = m;
            clear_group();
        endfunction

        function int pending();
            return expected_out.size();
        endfunction

        function void push_word(logic [7:0] d, logic last, logic bad);
            out_word_t w;
            w.data = d;
            w.last = last;
            w.bad  = bad;
            expected_out.push_back(w);
        endfunction

        function int symbol_index(logic [7:0] ch);
            for (int i = 0; i < 32; i++)
            begin
                if (alphabet[i] == ch)
                    return i;
            end
            return -1;
        endfunction

        // eight characters, padding after the kept ones for a short group
        function void emit_group(int nbytes);
            int keep;
            logic [7:0] ch;
            case (nbytes)
                1:       keep = 2;
                2:       keep = 4;
                3:       keep = 5;
                4:       keep = 7;
                default: keep = 8;
            endcase
            for (int i = 0; i < 8; i++)
            begin
                if (i < keep)
                    ch = alphabet[group_bits[39-5*i -: 5]];
                else
                    ch = PAD_CHAR;
                push_word(ch, i == 7, 1'b0);
            end
        endfunction

        function void encode_byte(logic [7:0] b, logic eos);
            int pos;
            pos = (group_cnt < 5) ? group_cnt : 4;
            group_bits[39-8*pos -: 8] = group_bits[39-8*pos -: 8] | b;
            group_cnt = pos + 1;
            if (group_cnt == 5)
            begin
                emit_group(5);
                clear_group();
            end
            else if (eos)
                emit_group(group_cnt);
            if (eos)
                clear_group();
        endfunction

        function void decode_char(logic [7:0] ch, logic eos);
            int v;
            int nbytes;
            if (error_latched)
            begin
                if (eos)
                    clear_group();
                return;
            end
            if (!pad_seen)
            begin
                if (ch == PAD_CHAR)
                    pad_seen = 1'b1;
                else
                begin
                    v = symbol_index(ch);
                    if (v < 0)
                    begin
                        push_word(8'h00, 1'b1, 1'b1);
                        error_latched = 1'b1;
                        clear_group();
                        return;
                    end
                    if (data_cnt < 8)
                    begin
                        group_bits[39-5*data_cnt -: 5] = v[4:0];
                        data_cnt++;
                    end
                end
            end
            if (group_cnt < 8)
                group_cnt++;
            if (group_cnt == 8)
            begin
                nbytes = (5 * data_cnt) / 8;
                for (int k = 0; k < nbytes; k++)
                    push_word(group_bits[39-8*k -: 8], k == nbytes - 1, 1'b0);
                clear_group();
            end
            if (eos)
                clear_group();
        endfunction

        function void note_input(logic [7:0] b, logic eos);
            if (decode_mode)
                decode_char(b, eos);
            else
                encode_byte(b, eos);
        endfunction

        function void check_output(logic [7:0] d, logic last, logic bad);
            out_word_t w;
            if (expected_out.size() == 0)
            begin
                $display("%0t: unexpected output word, actual out_byte %h last %b bad %b",
                         $time, d, last, bad);
                mismatches++;
                return;
            end
            w = expected_out.pop_front();
            if (d !== w.data)
            begin
                $display("%0t: out_byte mismatch, expected %h actual %h", $time, w.data, d);
                mismatches++;
            end
            if (last !== w.last)
            begin
                $display("%0t: last_of_run mismatch, expected %b actual %b", $time, w.last, last);
                mismatches++;
            end
            if (bad !== w.bad)
            begin
                $display("%0t: bad_input mismatch, expected %b actual %b", $time, w.bad, bad);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_stream = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       bad_input;

    base32_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold = 0;
    int items_sent = 0;
    int cycle_count = 0;

    base32_stream_codec_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .bad_input     (bad_input)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls plus a forced hold-off stretch
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            out_ready <= 1'b0;
            recv_hold--;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(in_byte, end_of_stream);
            if (out_valid && out_ready)
                sb.check_output(out_byte, last_of_run, bad_input);
        end
    end

    task automatic send_word(input logic [7:0] b, input logic eos);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= b;
        end_of_stream <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic end_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        // a word with no result may still be inside the block
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        end_input();
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        sb.set_mode(m);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic start_hold(input int cycles);
        @(posedge clk);
        recv_hold = cycles;
    endtask

    function automatic logic [7:0] rand_symbol();
        int idx;
        idx = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 31);
        if (idx < 26)
            return 8'(8'h41 + idx);
        return 8'(8'h32 + idx - 26);
    endfunction

    function automatic logic [7:0] rand_invalid();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h32 && c <= 8'h37) || c == PAD_CHAR);
        return c;
    endfunction

    task automatic send_enc_stream(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_word(b, i == len - 1);
        end
    endtask

    task automatic send_dec_group(input logic eos_last);
        int n_data;
        bit junk;
        logic [7:0] ch;
        if ($urandom_range(0, 3) == 0)
            n_data = $urandom_range(0, 8);
        else
            case ($urandom_range(0, 4))
                0:       n_data = 2;
                1:       n_data = 4;
                2:       n_data = 5;
                3:       n_data = 7;
                default: n_data = 8;
            endcase
        // characters after the pad are not checked, so sometimes make them garbage
        junk = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 8; i++)
        begin
            if (i < n_data)
                ch = rand_symbol();
            else if (i == n_data || !junk)
                ch = PAD_CHAR;
            else
                ch = 8'($urandom_range(0, 255));
            send_word(ch, eos_last && i == 7);
        end
    endtask

    task automatic send_dec_stream();
        int groups;
        int k;
        bit trunc;
        groups = $urandom_range(1, 3);
        trunc  = ($urandom_range(0, 4) == 0);
        for (int g = 0; g < groups; g++)
            send_dec_group(g == groups - 1 && !trunc);
        // short group closed by end of stream is dropped
        if (trunc)
        begin
            k = $urandom_range(1, 7);
            for (int i = 0; i < k; i++)
                send_word(rand_symbol(), i == k - 1);
        end
    endtask

    initial
    begin
        int mark;
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 59;

        // a mode write drops a partial group
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(8'h56, 1'b0);
        write_mode(1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'h80, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h01, 1'b1);
        // full group on the final word, no padding
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h0F, 1'b0);
        send_word(8'hF0, 1'b0);
        send_word(8'hAA, 1'b1);

        write_mode(1'b1);
        send_word("7", 1'b0);
        send_word("Z", 1'b0);
        send_word("2", 1'b0);
        send_word("A", 1'b0);
        send_word("M", 1'b0);
        send_word(PAD_CHAR, 1'b0);
        send_word("a", 1'b0);
        send_word(8'h00, 1'b0);
        send_word("A", 1'b0);
        send_word("B", 1'b1);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct = 59;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_idle_pct = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_mode(1'b0);
            mark = items_sent;
            if (ph == 0)
            begin
                // receiver holds off so the block backs up into its input
                start_hold(90);
                send_enc_stream(15);
                end_input();
                wait_drained();
            end
            while (items_sent - mark < 12)
                send_enc_stream($urandom_range(1, 12));
            write_mode(1'b1);
            mark = items_sent;
            while (items_sent - mark < 8)
                send_dec_stream();
        end

        // sticky error: one error word for the first bad character, then decode stays silent
        send_dec_group(1'b0);
        send_word(rand_symbol(), 1'b0);
        send_word(rand_symbol(), 1'b0);
        send_word(rand_symbol(), 1'b0);
        send_word(rand_invalid(), 1'b0);
        send_word("z", 1'b0);
        send_word(8'h00, 1'b0);
        send_dec_group(1'b1);

        write_mode(1'b0);
        send_enc_stream(7);
        send_enc_stream(3);

        end_input();
        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
